[sv/fpa_pkg.sv]
// Package for the fixed-point ALU: operation codes and word types.
// No dependencies; used by fpa_div and fixed_point_alu.
package fpa_pkg;

    // Operation codes carried in the op field.
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_NE       = 4'd8,
        OP_EQ       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_t;

    localparam int unsigned WORD_W = 32;

    // Input word.
    typedef struct packed {
        logic [3:0]               op;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                     compare_true;
        logic                     divide_by_zero;
    } out_word_t;

    // Side information that travels alongside the divider stages.
    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] res;
        logic              cmp;
        logic              dz;
        logic              qneg;
    } side_t;

endpackage

[sv/fpa_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on fpa_pkg for the word width.
module fpa_div #(
    parameter int unsigned DW = 40
) (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic [DW-1:0]                 dividend,
    input  logic [fpa_pkg::WORD_W-1:0]    divisor,
    output logic [DW-1:0]                 quotient
);

    localparam int unsigned W = fpa_pkg::WORD_W;

    // Per stage: shifting dividend/quotient, partial remainder, divisor.
    logic [DW-1:0] n_reg   [DW];
    logic [W-2:0]  rem_reg [DW];
    logic [W-1:0]  d_reg   [DW];

    genvar k;
    generate
        for (k = 0; k < DW; k++) begin : g_stage
            logic [DW-1:0] n_in;
            logic [W-2:0]  rem_in;
            logic [W-1:0]  d_in;
            logic [W-1:0]  trial;
            logic          fits;
            logic [W-1:0]  diff;

            if (k == 0) begin : g_first
                assign n_in   = dividend;
                assign rem_in = '0;
                assign d_in   = divisor;
            end else begin : g_next
                assign n_in   = n_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign d_in   = d_reg[k-1];
            end

            // Shift in the next dividend bit and try a subtract.
            assign trial = {rem_in, n_in[DW-1]};
            assign fits  = (trial >= d_in);
            assign diff  = trial - d_in;

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k] <= fits ? diff[W-2:0] : trial[W-2:0];
                    n_reg[k]   <= {n_in[DW-2:0], fits};
                    d_reg[k]   <= d_in;
                end
            end
        end
    endgenerate

    assign quotient = n_reg[DW-1];

endmodule

[sv/fixed_point_alu.sv]
// Top level of the signed fixed-point ALU with a deep pipeline.
// Depends on fpa_pkg and fpa_div.
//
// Usage: an input word (op, operand_a, operand_b) is accepted on the s_
// channel when s_valid and s_ready are both high; exactly one result word
// (result, compare_true, divide_by_zero) leaves on the m_ channel for each
// input word, in order.
// Every operation passes through the same stages: an input register, an
// operand stage with the multiplier, one stage per quotient bit of the
// restoring divider, and an output register. All operations take the same
// path so order is kept.
// Throughput is one word per cycle unless the receiver stalls; the divider pipeline sets the depth.
// When the receiver holds m_ready low with a word waiting, the whole
// pipeline freezes and s_ready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; words in flight
// are dropped.
module fixed_point_alu #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fpa_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fpa_pkg::out_word_t m_data
);

    localparam int unsigned W  = fpa_pkg::WORD_W;
    localparam int unsigned DW = W + FRAC_BITS;

    logic ce;
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // Stage 1: input register.
    logic               v1_reg;
    fpa_pkg::in_word_t  in1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            in1_reg <= s_data;
        end
    end

    // Stage 2: simple operations, multiply, operand magnitudes.
    logic signed [W-1:0]   a;
    logic signed [W-1:0]   b;
    fpa_pkg::op_t          op1;
    logic [W-1:0]          res1;
    logic                  cmp1;
    logic signed [2*W-1:0] prod1;
    logic [W-1:0]          abs_a;
    logic [W-1:0]          abs_b;

    assign a     = in1_reg.operand_a;
    assign b     = in1_reg.operand_b;
    assign op1   = fpa_pkg::op_t'(in1_reg.op);
    assign prod1 = a * b;
    assign abs_a = a[W-1] ? (W)'(-a) : a;
    assign abs_b = b[W-1] ? (W)'(-b) : b;

    always_comb begin
        res1 = '0;
        cmp1 = 1'b0;
        unique case (op1)
            fpa_pkg::OP_ADD:      res1 = a + b;
            fpa_pkg::OP_SUB:      res1 = a - b;
            fpa_pkg::OP_MUL:      res1 = '0;
            fpa_pkg::OP_DIV:      res1 = '0;
            fpa_pkg::OP_GT:       cmp1 = (a > b);
            fpa_pkg::OP_LT:       cmp1 = (a < b);
            fpa_pkg::OP_GE:       cmp1 = (a >= b);
            fpa_pkg::OP_LE:       cmp1 = (a <= b);
            fpa_pkg::OP_NE:       cmp1 = (a != b);
            fpa_pkg::OP_EQ:       cmp1 = (a == b);
            fpa_pkg::OP_MIN:      res1 = (a < b) ? a : b;
            fpa_pkg::OP_MAX:      res1 = (a > b) ? a : b;
            fpa_pkg::OP_INC:      res1 = a + W'(1);
            fpa_pkg::OP_DEC:      res1 = a - W'(1);
            fpa_pkg::OP_FROM_INT: res1 = a <<< FRAC_BITS;
            fpa_pkg::OP_TO_INT:   res1 = a >>> FRAC_BITS;
            default:              res1 = '0;
        endcase
    end

    logic                  v2_reg;
    fpa_pkg::side_t        side2_reg;
    logic signed [2*W-1:0] prod2_reg;
    logic [DW-1:0]         dvd2_reg;
    logic [W-1:0]          dvs2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side2_reg.op   <= op1;
            side2_reg.res  <= res1;
            side2_reg.cmp  <= cmp1;
            side2_reg.dz   <= (op1 == fpa_pkg::OP_DIV) && (b == '0);
            side2_reg.qneg <= a[W-1] ^ b[W-1];
            prod2_reg      <= prod1;
            dvd2_reg       <= {abs_a, {FRAC_BITS{1'b0}}};
            dvs2_reg       <= abs_b;
        end
    end

    // Divider stages, with side information delayed to match.
    logic [DW-1:0] quot;

    fpa_div #(.DW(DW)) u_div (
        .aclk     (aclk),
        .ce       (ce),
        .dividend (dvd2_reg),
        .divisor  (dvs2_reg),
        .quotient (quot)
    );

    fpa_pkg::side_t        side_next;
    logic signed [2*W-1:0] prod_shift;

    assign prod_shift = prod2_reg >>> FRAC_BITS;

    // For a multiply, the scaled product replaces the result as the word enters the line.
    always_comb begin
        side_next = side2_reg;
        if (side2_reg.op == fpa_pkg::OP_MUL) begin
            side_next.res = prod_shift[W-1:0];
        end
    end

    logic [DW-1:0]  line_v_reg;
    fpa_pkg::side_t side_reg [DW];

    // Valid bits of the delay line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_v_reg <= '0;
        end else if (ce) begin
            line_v_reg <= {line_v_reg[DW-2:0], v2_reg};
        end
    end

    // Side information shifts along with the divider stages.
    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DW; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Output stage: sign the quotient and pick the final result.
    fpa_pkg::side_t     last;
    logic [DW-1:0]      squot;
    fpa_pkg::out_word_t out_next;

    assign last  = side_reg[DW-1];
    assign squot = last.qneg ? (DW)'(-quot) : quot;

    always_comb begin
        out_next.result         = last.res;
        out_next.compare_true   = last.cmp;
        out_next.divide_by_zero = last.dz;
        if (last.op == fpa_pkg::OP_DIV && !last.dz) begin
            out_next.result = squot[W-1:0];
        end
    end

    logic               m_valid_reg;
    fpa_pkg::out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= line_v_reg[DW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[verif/fixed_point_alu_test.sv]
// Self-checking testbench for fixed_point_alu with the default FRAC_BITS.
// Depends on fpa_pkg and the fixed_point_alu RTL; a small scoreboard class predicts results.
module fixed_point_alu_test;

    localparam int unsigned FRAC = 8;
    localparam int unsigned LATENCY = 32 + FRAC + 3;

    // Predicts each result word and holds the expected words in order.
    class alu_scoreboard;
        fpa_pkg::out_word_t pending_words[$];
        int mismatches;

        function fpa_pkg::out_word_t compute(fpa_pkg::in_word_t w);
            fpa_pkg::out_word_t r;
            logic signed [63:0] a64;
            logic signed [63:0] b64;
            logic signed [63:0] prod;
            logic signed [63:0] quot;
            logic signed [63:0] shifted;
            a64 = 64'(signed'(w.operand_a));
            b64 = 64'(signed'(w.operand_b));
            r = '0;
            case (fpa_pkg::op_t'(w.op))
                fpa_pkg::OP_ADD: r.result = w.operand_a + w.operand_b;
                fpa_pkg::OP_SUB: r.result = w.operand_a - w.operand_b;
                fpa_pkg::OP_MUL: begin
                    prod = a64 * b64;
                    r.result = prod[FRAC +: 32];
                end
                fpa_pkg::OP_DIV: begin
                    if (w.operand_b == 0) begin
                        r.divide_by_zero = 1'b1;
                    end else begin
                        quot = (a64 <<< FRAC) / b64;
                        r.result = quot[31:0];
                    end
                end
                fpa_pkg::OP_GT: r.compare_true = a64 > b64;
                fpa_pkg::OP_LT: r.compare_true = a64 < b64;
                fpa_pkg::OP_GE: r.compare_true = a64 >= b64;
                fpa_pkg::OP_LE: r.compare_true = a64 <= b64;
                fpa_pkg::OP_NE: r.compare_true = a64 != b64;
                fpa_pkg::OP_EQ: r.compare_true = a64 == b64;
                fpa_pkg::OP_MIN: r.result = (a64 < b64) ? w.operand_a : w.operand_b;
                fpa_pkg::OP_MAX: r.result = (a64 > b64) ? w.operand_a : w.operand_b;
                fpa_pkg::OP_INC: r.result = w.operand_a + 32'sd1;
                fpa_pkg::OP_DEC: r.result = w.operand_a - 32'sd1;
                fpa_pkg::OP_FROM_INT: r.result = w.operand_a << FRAC;
                default: begin
                    shifted = a64 >>> FRAC;
                    r.result = shifted[31:0];
                end
            endcase
            return r;
        endfunction

        function void note_input(fpa_pkg::in_word_t w);
            pending_words.push_back(compute(w));
        endfunction

        function void check_result(fpa_pkg::out_word_t got);
            fpa_pkg::out_word_t want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = pending_words.pop_front();
            if (got.result !== want.result || got.compare_true !== want.compare_true
                    || got.divide_by_zero !== want.divide_by_zero) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected res=%h cmp=%b dz=%b, got res=%h cmp=%b dz=%b",
                             want.result, want.compare_true, want.divide_by_zero,
                             got.result, got.compare_true, got.divide_by_zero);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    fpa_pkg::in_word_t  s_data;
    logic               m_valid;
    logic               m_ready;
    fpa_pkg::out_word_t m_data;

    alu_scoreboard board;
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_off_cycles;

    fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Picks an operand with a bias toward extremes and small values.
    function logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(0, 8)) - 4);
            3: return 32'(signed'($urandom_range(0, 4095)) - 2048);
            4: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Offers one word and waits until it is accepted. Valid drops only
    // while the sender idles, so words can follow back to back.
    task send_word(fpa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
        fpa_pkg::in_word_t w;
        w.op = op;
        w.operand_a = a;
        w.operand_b = b;
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(w);
    endtask

    task send_random(int count);
        for (int i = 0; i < count; i++)
            send_word(fpa_pkg::op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                board.check_result(m_data);
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("fixed_point_alu_test: FAIL");
        $finish;
    end

    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_off_cycles = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: every operation with extremes and divide by zero.
        for (int o = 0; o < 16; o++)
            send_word(fpa_pkg::op_t'(o), 32'h8000_0000, 32'hffff_ffff);
        send_word(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0);
        send_word(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_word(fpa_pkg::OP_DIV, 32'hffff_ff01, 32'h0000_0300);
        send_word(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(fpa_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_word(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'h0);
        send_word(fpa_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678);
        send_word(fpa_pkg::OP_TO_INT, 32'hffff_ff01, 32'h0);
        send_word(fpa_pkg::OP_MIN, 32'h7fff_ffff, 32'h8000_0000);

        sender_idle_pct = 8;
        receiver_idle_pct = 65;
        send_random(450);

        // Long receiver stall while the sender keeps offering words.
        hold_off_cycles = 200;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        send_random(100);

        sender_idle_pct = 65;
        receiver_idle_pct = 8;
        send_random(450);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        send_random(450);
        s_valid <= 1'b0;

        while (board.pending_words.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("fixed_point_alu_test: PASS");
        else
            $display("fixed_point_alu_test: FAIL");
        $finish;
    end
endmodule
